>>> hw/rtl/epoch_seconds_to_datetime_core_defines.svh
// Assertion macros for the epoch seconds to date/time core.
// Used by the bound checker; expects clk_i and rst_ni in scope.
`ifndef EPOCH_SECONDS_TO_DATETIME_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATETIME_CORE_DEFINES_SVH

// clocked property, disabled while in reset
`define E2D_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("e2d check failed");

// same-cycle implication
`define E2D_IMPLY(label, ante, cons) \
  `E2D_ASSERT(label, (ante) |-> (cons))

`endif

>>> hw/rtl/e2d_pkg.sv
// Shared types and constants for the epoch seconds to date/time core.
// No dependencies.
package e2d_pkg;

  typedef struct packed {
    logic signed [34:0] whole_seconds;
    logic        [15:0] sub_second;
  } in_word_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [15:0] fraction_out;
    logic        range_error;
  } out_word_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        range_error;
  } date_t;

  localparam int unsigned MIN_YEAR = 1900;
  localparam int unsigned MAX_YEAR = 2099;

  localparam longint unsigned SEC_PER_DAY  = 86400;
  localparam longint unsigned HALF_DAY     = 43200;
  localparam int unsigned     DAYS_PER_ERA = 146097;
  localparam int unsigned     MARCH_SHIFT  = 60;
  localparam int unsigned     SEC_PER_HOUR = 3600;
  localparam int unsigned     SEC_PER_MIN  = 60;

  // bias days and eras so every intermediate stays non-negative
  localparam longint unsigned DAY_BIAS = 200000;
  localparam int unsigned     ERA_BIAS = 2;
  localparam logic [35:0] SEC_OFFSET = 36'(DAY_BIAS * SEC_PER_DAY + HALF_DAY);
  localparam logic [18:0] DAY_OFFSET =
    19'(ERA_BIAS * DAYS_PER_ERA - int'(DAY_BIAS) - MARCH_SHIFT);
  localparam int unsigned YEAR_BASE = 2000 - 400 * ERA_BIAS;

  // seconds / 86400 done as (seconds >> 7) / 675
  localparam longint unsigned DAY_DIV   = SEC_PER_DAY / 128;
  localparam logic [29:0]     DAY_RECIP = 30'(((64'd1 << 39) + DAY_DIV - 1) / DAY_DIV);

  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 3599) / 3600);
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 59) / 60);
  localparam logic [18:0] R1460      = 19'(((64'd1 << 29) + 1459) / 1460);
  localparam logic [18:0] R36524     = 19'(((64'd1 << 34) + 36523) / 36524);
  localparam logic [18:0] R365       = 19'(((64'd1 << 27) + 364) / 365);
  localparam logic [9:0]  R100       = 10'(((64'd1 << 16) + 99) / 100);
  localparam logic [11:0] R153       = 12'(((64'd1 << 19) + 152) / 153);
  localparam logic [11:0] R5         = 12'(((64'd1 << 14) + 4) / 5);

  localparam int unsigned SPLIT_LAT = 3;
  localparam int unsigned TOD_LAT   = 4;
  localparam int unsigned CIVIL_LAT = 9;
  localparam int unsigned PIPE_LAT  = SPLIT_LAT + CIVIL_LAT;

endpackage

>>> hw/rtl/e2d_day_split.sv
// Splits biased seconds into a day count and second of day (3 stages).
// Depends on e2d_pkg.
module e2d_day_split (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [34:0] secs_i,
  output logic               valid_o,
  output logic [16:0]        sod_o,
  output logic [18:0]        wday_o
);

  logic [e2d_pkg::SPLIT_LAT-1:0] vld_q;
  logic [35:0] u_q, u_d;
  logic [58:0] prod;
  logic [18:0] q_q;
  logic [28:0] v_q;
  logic [6:0]  lo_q;
  logic [28:0] rem_full;
  logic [16:0] sod_q;
  logic [18:0] w_q;

  assign u_d      = {secs_i[34], secs_i} + e2d_pkg::SEC_OFFSET;
  assign prod     = u_q[35:7] * e2d_pkg::DAY_RECIP;
  assign rem_full = v_q - ({10'd0, q_q} * 29'(e2d_pkg::DAY_DIV));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[e2d_pkg::SPLIT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    q_q   <= prod[57:39];
    v_q   <= u_q[35:7];
    lo_q  <= u_q[6:0];
    sod_q <= {rem_full[9:0], lo_q};
    w_q   <= q_q + e2d_pkg::DAY_OFFSET;
  end

  assign valid_o = vld_q[e2d_pkg::SPLIT_LAT-1];
  assign sod_o   = sod_q;
  assign wday_o  = w_q;

endmodule

>>> hw/rtl/e2d_tod.sv
// Second of day to hour, minute, second (4 stages).
// Depends on e2d_pkg.
module e2d_tod (
  input  logic               clk_i,
  input  logic [16:0]        sod_i,
  output e2d_pkg::tod_t      tod_o
);

  logic [34:0] ph;
  logic [24:0] pm;
  logic [16:0] sod1_q;
  logic [4:0]  hour1_q, hour2_q, hour3_q;
  logic [11:0] rem2_q, rem3_q;
  logic [5:0]  min3_q;
  e2d_pkg::tod_t tod_q;

  assign ph = sod_i * e2d_pkg::HOUR_RECIP;
  assign pm = rem2_q * e2d_pkg::MIN_RECIP;

  always_ff @(posedge clk_i) begin
    sod1_q       <= sod_i;
    hour1_q      <= ph[33:29];
    rem2_q       <= 12'(sod1_q - 17'(hour1_q) * 17'(e2d_pkg::SEC_PER_HOUR));
    hour2_q      <= hour1_q;
    min3_q       <= pm[23:18];
    rem3_q       <= rem2_q;
    hour3_q      <= hour2_q;
    tod_q.hour   <= hour3_q;
    tod_q.minute <= min3_q;
    tod_q.second <= 6'(rem3_q - 12'(min3_q) * 12'(e2d_pkg::SEC_PER_MIN));
  end

  assign tod_o = tod_q;

endmodule

>>> hw/rtl/e2d_civil.sv
// Biased day count to Gregorian year, month, day and range flag (9 stages).
// Depends on e2d_pkg.
module e2d_civil (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [18:0]    wday_i,
  output logic           valid_o,
  output e2d_pkg::date_t date_o
);

  localparam logic [18:0] Era1 = 19'(e2d_pkg::DAYS_PER_ERA);
  localparam logic [18:0] Era2 = 19'(2 * e2d_pkg::DAYS_PER_ERA);
  localparam logic [18:0] Era3 = 19'(3 * e2d_pkg::DAYS_PER_ERA);

  logic [e2d_pkg::CIVIL_LAT-1:0] vld_q;

  logic [1:0]  era_d;
  logic [18:0] base_d;
  logic [1:0]  era1_q, era2_q, era3_q, era4_q, era5_q, era6_q, era7_q, era8_q;
  logic [17:0] doe1_q, doe2_q, doe3_q, doe4_q, doe5_q;
  logic [36:0] p1460, p36524, p365;
  logic [6:0]  q1460_q;
  logic [2:0]  q36524_q;
  logic        leap_q;
  logic [17:0] t_q;
  logic [8:0]  yoe4_q, yoe5_q, yoe6_q, yoe7_q, yoe8_q;
  logic [18:0] p100;
  logic [1:0]  c100_q;
  logic [8:0]  doy6_q, doy7_q, doy8_q;
  logic [10:0] n7, n8;
  logic [22:0] p153, p5;
  logic [3:0]  mp_q, month_q;
  logic [8:0]  d5_q;
  logic [11:0] year;
  logic [8:0]  day9;
  logic        bad;
  e2d_pkg::date_t date_q;

  always_comb begin
    if (wday_i >= Era3) begin
      era_d  = 2'd3;
      base_d = Era3;
    end else if (wday_i >= Era2) begin
      era_d  = 2'd2;
      base_d = Era2;
    end else if (wday_i >= Era1) begin
      era_d  = 2'd1;
      base_d = Era1;
    end else begin
      era_d  = 2'd0;
      base_d = '0;
    end
  end

  assign p1460  = doe1_q * e2d_pkg::R1460;
  assign p36524 = doe1_q * e2d_pkg::R36524;
  assign p365   = t_q * e2d_pkg::R365;
  assign p100   = yoe4_q * e2d_pkg::R100;
  assign n7     = 11'({doy6_q, 2'b00}) + 11'(doy6_q) + 11'd2;
  assign p153   = n7 * e2d_pkg::R153;
  assign n8     = 11'(mp_q) * 11'd153 + 11'd2;
  assign p5     = n8 * e2d_pkg::R5;

  assign year = 12'(e2d_pkg::YEAR_BASE) + 12'(era8_q) * 12'd400 + 12'(yoe8_q)
              + 12'(month_q <= 4'd2);
  assign day9 = doy8_q - d5_q + 9'd1;
  assign bad  = (year < 12'(e2d_pkg::MIN_YEAR)) || (year > 12'(e2d_pkg::MAX_YEAR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[e2d_pkg::CIVIL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // era and day of era
    era1_q   <= era_d;
    doe1_q   <= 18'(wday_i - base_d);
    // century and four-year corrections
    q1460_q  <= p1460[35:29];
    q36524_q <= p36524[36:34];
    leap_q   <= (doe1_q == 18'(e2d_pkg::DAYS_PER_ERA - 1));
    doe2_q   <= doe1_q;
    era2_q   <= era1_q;
    t_q      <= doe2_q - 18'(q1460_q) + 18'(q36524_q) - 18'(leap_q);
    doe3_q   <= doe2_q;
    era3_q   <= era2_q;
    // year of era
    yoe4_q   <= p365[35:27];
    doe4_q   <= doe3_q;
    era4_q   <= era3_q;
    c100_q   <= p100[17:16];
    yoe5_q   <= yoe4_q;
    doe5_q   <= doe4_q;
    era5_q   <= era4_q;
    // day of year, March based
    doy6_q   <= 9'(doe5_q - (18'(yoe5_q) * 18'd365 + 18'(yoe5_q[8:2]) - 18'(c100_q)));
    yoe6_q   <= yoe5_q;
    era6_q   <= era5_q;
    mp_q     <= p153[22:19];
    doy7_q   <= doy6_q;
    yoe7_q   <= yoe6_q;
    era7_q   <= era6_q;
    d5_q     <= p5[22:14];
    month_q  <= (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
    doy8_q   <= doy7_q;
    yoe8_q   <= yoe7_q;
    era8_q   <= era7_q;
    // final assembly
    date_q.year        <= bad ? '0 : year;
    date_q.month       <= bad ? '0 : month_q;
    date_q.day         <= bad ? '0 : day9[4:0];
    date_q.range_error <= bad;
  end

  assign valid_o = vld_q[e2d_pkg::CIVIL_LAT-1];
  assign date_o  = date_q;

endmodule

>>> hw/rtl/epoch_seconds_to_datetime_core.sv
// Top level of the epoch seconds to date/time core.
// Depends on e2d_pkg, e2d_day_split, e2d_tod, e2d_civil.
//
// Converts signed seconds from 2000-01-01 12:00:00 into a Gregorian date and
// time of day. A word is taken on every clock edge with start high; busy is
// always low. Each word gives one result on result_o, marked by done_o for one
// cycle, once it has passed the day/second split and then the calendar
// arithmetic, with time of day worked out alongside. Results leave in input
// order and cannot be held off. Years outside 1900..2099 set range_error and
// zero year, month and day; time of day is always valid.
module epoch_seconds_to_datetime_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  e2d_pkg::in_word_t  in_i,
  output logic               done_o,
  output e2d_pkg::out_word_t result_o
);

  localparam int unsigned TodPad = e2d_pkg::CIVIL_LAT - e2d_pkg::TOD_LAT;

  logic           split_vld;
  logic [16:0]    sod;
  logic [18:0]    wday;
  e2d_pkg::tod_t  tod;
  e2d_pkg::date_t date;
  logic           civil_vld;

  logic [15:0]   frac_q [e2d_pkg::PIPE_LAT];
  e2d_pkg::tod_t tod_q  [TodPad];

  assign busy = 1'b0;

  e2d_day_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .secs_i  (in_i.whole_seconds),
    .valid_o (split_vld),
    .sod_o   (sod),
    .wday_o  (wday)
  );

  e2d_tod u_tod (
    .clk_i (clk_i),
    .sod_i (sod),
    .tod_o (tod)
  );

  e2d_civil u_civil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_vld),
    .wday_i  (wday),
    .valid_o (civil_vld),
    .date_o  (date)
  );

  always_ff @(posedge clk_i) begin
    frac_q[0] <= in_i.sub_second;
    for (int i = 1; i < e2d_pkg::PIPE_LAT; i++) begin
      frac_q[i] <= frac_q[i-1];
    end
    tod_q[0] <= tod;
    for (int i = 1; i < TodPad; i++) begin
      tod_q[i] <= tod_q[i-1];
    end
  end

  assign done_o                = civil_vld;
  assign result_o.year_out     = date.year;
  assign result_o.month_out    = date.month;
  assign result_o.day_out      = date.day;
  assign result_o.hour_out     = tod_q[TodPad-1].hour;
  assign result_o.minute_out   = tod_q[TodPad-1].minute;
  assign result_o.second_out   = tod_q[TodPad-1].second;
  assign result_o.fraction_out = frac_q[e2d_pkg::PIPE_LAT-1];
  assign result_o.range_error  = date.range_error;

endmodule

>>> hw/rtl/e2d_checker.sv
// Port-level checks for epoch_seconds_to_datetime_core, bound to the top.
// Depends on e2d_pkg and epoch_seconds_to_datetime_core_defines.svh.
`include "epoch_seconds_to_datetime_core_defines.svh"

module e2d_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input e2d_pkg::in_word_t  in_i,
  input logic               done_o,
  input e2d_pkg::out_word_t result_o
);

  localparam int unsigned Lat = e2d_pkg::PIPE_LAT;

  `E2D_ASSERT(a_word_returns, (start && !busy) |-> ##Lat done_o)
  `E2D_ASSERT(a_no_spurious, done_o |-> $past(start && !busy, Lat))
  `E2D_ASSERT(a_fraction_kept, (start && !busy) |-> ##Lat (result_o.fraction_out == $past(in_i.sub_second, Lat)))
  `E2D_IMPLY(a_flag_clears_date, done_o && result_o.range_error, result_o.year_out == 12'd0 && result_o.month_out == 4'd0 && result_o.day_out == 5'd0)
  `E2D_IMPLY(a_fields_legal, done_o && !result_o.range_error, result_o.month_out >= 4'd1 && result_o.month_out <= 4'd12 && result_o.day_out >= 5'd1 && result_o.hour_out <= 5'd23)

endmodule

bind epoch_seconds_to_datetime_core e2d_checker u_e2d_checker (.*);
